FILE: sv/slcv_pkg.sv
package slcv_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    // Divider geometry: quotient bits, dividend width, divisor width
    localparam int QW = 65;
    localparam int NW = 70;
    localparam int DW = 63;

    localparam logic [7:0] REC_FULL     = 8'd1;
    localparam logic [6:0] LIN_RECIP    = 7'd7;
    localparam logic [1:0] FMT_UNSIGNED = 2'd0;

    typedef enum logic [2:0] {
        REG_RECORD_TYPE     = 3'd0,
        REG_MULTIPLIER_M    = 3'd1,
        REG_OFFSET_B        = 3'd2,
        REG_OFFSET_EXPONENT = 3'd3,
        REG_RESULT_EXPONENT = 3'd4,
        REG_READING_FORMAT  = 3'd5,
        REG_LINEARIZATION   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic valid;
        logic neg;
    } div_ctl_t;

    typedef struct packed {
        logic valid;
        logic neg;
        logic ovf;
    } div_res_t;

    function automatic logic [53:0] pow10(input logic [4:0] e);
        logic [53:0] p;
        p = 54'd1;
        unique case (e)
            5'd0:  p = 54'd1;
            5'd1:  p = 54'd10;
            5'd2:  p = 54'd100;
            5'd3:  p = 54'd1000;
            5'd4:  p = 54'd10000;
            5'd5:  p = 54'd100000;
            5'd6:  p = 54'd1000000;
            5'd7:  p = 54'd10000000;
            5'd8:  p = 54'd100000000;
            5'd9:  p = 54'd1000000000;
            5'd10: p = 54'd10000000000;
            5'd11: p = 54'd100000000000;
            5'd12: p = 54'd1000000000000;
            5'd13: p = 54'd10000000000000;
            5'd14: p = 54'd100000000000000;
            5'd15: p = 54'd1000000000000000;
            5'd16: p = 54'd10000000000000000;
            default: p = 54'd1;
        endcase
        return p;
    endfunction

endpackage

FILE: sv/slcv_div.sv
module slcv_div #(
    parameter int FRACTION_BITS = slcv_pkg::FRACTION_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  slcv_pkg::div_ctl_t           ctl,
    input  logic [slcv_pkg::NW-1:0]      n,
    input  logic [slcv_pkg::DW-1:0]      d,
    output slcv_pkg::div_res_t           res,
    output logic [slcv_pkg::QW-1:0]      q
);
    import slcv_pkg::*;

    localparam int HI_SHIFT = QW - 1 - FRACTION_BITS;

    logic              v_reg   [0:QW];
    logic              neg_reg [0:QW];
    logic              ovf_reg [0:QW];
    logic [DW-1:0]     r_reg   [0:QW];
    logic [DW-1:0]     d_reg   [0:QW];
    logic [QW-1:0]     qx_reg  [0:QW];

    logic [NW-1:0]     n_hi;
    logic [NW-1:0]     n_shl;

    // Dividend is n * 2^(F+1); the part above the quotient width seeds the remainder
    assign n_hi  = n >> HI_SHIFT;
    assign n_shl = n << (FRACTION_BITS + 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg[0] <= ctl.neg;
        ovf_reg[0] <= (n_hi >= NW'(d));
        r_reg[0]   <= n_hi[DW-1:0];
        d_reg[0]   <= d;
        qx_reg[0]  <= n_shl[QW-1:0];
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [DW:0]   r2;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] r_next;

        assign r2     = {r_reg[s], qx_reg[s][QW-1]};
        assign diff   = r2 - {1'b0, d_reg[s]};
        assign ge     = (r2 >= {1'b0, d_reg[s]});
        assign r_next = ge ? diff[DW-1:0] : r2[DW-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            neg_reg[s+1] <= neg_reg[s];
            ovf_reg[s+1] <= ovf_reg[s];
            r_reg[s+1]   <= r_next;
            d_reg[s+1]   <= d_reg[s];
            qx_reg[s+1]  <= {qx_reg[s][QW-2:0], ge};
        end
    end

    assign res.valid = v_reg[QW];
    assign res.neg   = neg_reg[QW];
    assign res.ovf   = ovf_reg[QW];
    assign q         = qx_reg[QW];

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[QW] && !ovf_reg[QW]) |-> (r_reg[QW] < d_reg[QW]))
        else $error("remainder not below divisor");

endmodule

FILE: sv/sensor_reading_linear_convert_unit.sv
// Sensor reading linear converter.
// Pulse start with raw_reading while busy is low; the word is taken at that
// clock edge. busy stays low: a new reading may be started every cycle.
// Each reading yields one result: converted_value (signed, FRACTION_BITS
// fraction bits) and overflow, shown for exactly one cycle with done high.
// The result passes five stages that build the formula value and pick dividend
// and divisor, one stage that seeds the divider, then a long divider that
// resolves one quotient bit per stage over 65 stages, and one stage that
// registers the rounded, saturated output. Results leave in start order.
// The record registers are written through wr_en / wr_index / wr_data,
// one register per cycle; change them only while no reading is in flight.
// Reset clears the pipeline valid bits and loads the register defaults
// (full record, M = 1, all else zero). The receiver cannot hold results
// off; done is a strobe and each word must be taken when shown.
module sensor_reading_linear_convert_unit #(
    parameter int FRACTION_BITS = slcv_pkg::FRACTION_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         raw_reading,
    input  logic               wr_en,
    input  logic [2:0]         wr_index,
    input  logic [9:0]         wr_data,
    output logic               done,
    output logic signed [63:0] converted_value,
    output logic               overflow
);
    import slcv_pkg::*;

    localparam int LAT = 5 + 1 + QW + 1;
    localparam logic [63:0] MAX_POS = {1'b0, {63{1'b1}}};
    localparam logic [63:0] MAX_NEG = {1'b1, {63{1'b0}}};

    // Configuration registers
    logic [7:0]        record_type_reg;
    logic signed [9:0] multiplier_m_reg;
    logic signed [9:0] offset_b_reg;
    logic signed [3:0] offset_exponent_reg;
    logic signed [3:0] result_exponent_reg;
    logic [1:0]        reading_format_reg;
    logic [6:0]        linearization_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_type_reg     <= REC_FULL;
            multiplier_m_reg    <= 10'sd1;
            offset_b_reg        <= '0;
            offset_exponent_reg <= '0;
            result_exponent_reg <= '0;
            reading_format_reg  <= '0;
            linearization_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_RECORD_TYPE:     record_type_reg     <= wr_data[7:0];
                REG_MULTIPLIER_M:    multiplier_m_reg    <= wr_data;
                REG_OFFSET_B:        offset_b_reg        <= wr_data;
                REG_OFFSET_EXPONENT: offset_exponent_reg <= wr_data[3:0];
                REG_RESULT_EXPONENT: result_exponent_reg <= wr_data[3:0];
                REG_READING_FORMAT:  reading_format_reg  <= wr_data[1:0];
                REG_LINEARIZATION:   linearization_reg   <= wr_data[6:0];
                default: ;
            endcase
        end
    end

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Stage A: decode exponents, M*x and B*10^max(Bexp,0)
    logic signed [8:0]  x_s;
    logic [3:0]         sh1_next;
    logic [4:0]         sh2_next;
    logic signed [5:0]  emin_next;
    logic signed [18:0] mx_next;
    logic signed [34:0] bt_next;
    logic [53:0]        p_sh2;

    assign x_s      = (reading_format_reg == FMT_UNSIGNED) ? $signed({1'b0, raw_reading})
                                                           : $signed({raw_reading[7], raw_reading});
    assign sh1_next = offset_exponent_reg[3] ? 4'(-$signed({offset_exponent_reg[3],
                                                            offset_exponent_reg})) : 4'd0;
    assign sh2_next = offset_exponent_reg[3] ? 5'd0 : {2'b00, offset_exponent_reg[2:0]};
    assign emin_next = 6'(result_exponent_reg)
                     + (offset_exponent_reg[3] ? 6'(offset_exponent_reg) : 6'sd0);
    assign p_sh2    = pow10(sh2_next);
    assign mx_next  = multiplier_m_reg * x_s;
    assign bt_next  = offset_b_reg * $signed({1'b0, p_sh2[23:0]});

    logic               a_v_reg;
    logic               a_pass_reg, a_recip_reg;
    logic [7:0]         a_raw_reg;
    logic signed [18:0] a_mx_reg;
    logic signed [34:0] a_bt_reg;
    logic [3:0]         a_sh1_reg;
    logic signed [5:0]  a_emin_reg;

    // Stage B: (M*x) * 10^sh1
    logic [53:0]        p_sh1;
    logic signed [46:0] p_next;
    assign p_sh1  = pow10({1'b0, a_sh1_reg});
    assign p_next = a_mx_reg * $signed({1'b0, p_sh1[26:0]});

    logic               b_v_reg;
    logic               b_pass_reg, b_recip_reg;
    logic [7:0]         b_raw_reg;
    logic signed [46:0] b_p_reg;
    logic signed [34:0] b_bt_reg;
    logic signed [5:0]  b_emin_reg;

    // Stage C: sum, split sign and magnitude
    logic signed [47:0] acc;
    logic signed [47:0] acc_abs;
    assign acc     = 48'(b_p_reg) + 48'(b_bt_reg);
    assign acc_abs = acc[47] ? -acc : acc;

    logic              c_v_reg;
    logic              c_pass_reg, c_recip_reg, c_neg_reg;
    logic [7:0]        c_raw_reg;
    logic [45:0]       c_mag_reg;
    logic signed [5:0] c_emin_reg;

    // Stage D: magnitude * 10^max(emin,0)
    logic [53:0] p_emin;
    logic [69:0] prod_next;
    assign p_emin    = pow10(c_emin_reg[5] ? 5'd0 : 5'(c_emin_reg));
    assign prod_next = c_mag_reg * p_emin[23:0];

    logic              d_v_reg;
    logic              d_pass_reg, d_recip_reg, d_neg_reg;
    logic [7:0]        d_raw_reg;
    logic [45:0]       d_mag_reg;
    logic [69:0]       d_prod_reg;
    logic signed [5:0] d_emin_reg;

    // Stage E: choose dividend and divisor
    logic [53:0]   p_nemin;
    logic [NW-1:0] n_next;
    logic [DW-1:0] dv_next;
    logic          neg_e_next;
    assign p_nemin = pow10(5'(-d_emin_reg));

    always_comb
    begin
        n_next     = '0;
        dv_next    = DW'(1);
        neg_e_next = d_neg_reg;
        priority if (d_pass_reg)
        begin
            n_next     = NW'(d_raw_reg);
            neg_e_next = 1'b0;
        end
        else if (d_recip_reg && d_mag_reg == '0)
        begin
            // reciprocal of zero: drive far past full scale to saturate positive
            n_next     = {1'b1, {(NW-1){1'b0}}};
            neg_e_next = 1'b0;
        end
        else if (d_recip_reg && d_emin_reg[5])
        begin
            n_next  = NW'(p_nemin);
            dv_next = DW'(d_mag_reg);
        end
        else if (d_recip_reg)
        begin
            if (d_prod_reg[69:DW] == '0)
            begin
                n_next  = NW'(1);
                dv_next = d_prod_reg[DW-1:0];
            end
        end
        else if (d_emin_reg[5])
        begin
            n_next  = NW'(d_mag_reg);
            dv_next = DW'(p_nemin);
        end
        else
        begin
            n_next = d_prod_reg;
        end
    end

    logic          e_v_reg;
    logic          e_neg_reg;
    div_ctl_t      e_ctl;
    logic [NW-1:0] e_n_reg;
    logic [DW-1:0] e_d_reg;

    assign e_ctl = '{valid: e_v_reg, neg: e_neg_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= accept;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_pass_reg  <= (record_type_reg != REC_FULL);
        a_recip_reg <= (linearization_reg == LIN_RECIP) && (raw_reading != 8'd0);
        a_raw_reg   <= raw_reading;
        a_mx_reg    <= mx_next;
        a_bt_reg    <= bt_next;
        a_sh1_reg   <= sh1_next;
        a_emin_reg  <= emin_next;

        b_pass_reg  <= a_pass_reg;
        b_recip_reg <= a_recip_reg;
        b_raw_reg   <= a_raw_reg;
        b_p_reg     <= p_next;
        b_bt_reg    <= a_bt_reg;
        b_emin_reg  <= a_emin_reg;

        c_pass_reg  <= b_pass_reg;
        c_recip_reg <= b_recip_reg;
        c_raw_reg   <= b_raw_reg;
        c_neg_reg   <= acc[47];
        c_mag_reg   <= acc_abs[45:0];
        c_emin_reg  <= b_emin_reg;

        d_pass_reg  <= c_pass_reg;
        d_recip_reg <= c_recip_reg;
        d_raw_reg   <= c_raw_reg;
        d_neg_reg   <= c_neg_reg;
        d_mag_reg   <= c_mag_reg;
        d_prod_reg  <= prod_next;
        d_emin_reg  <= c_emin_reg;

        e_neg_reg <= neg_e_next;
        e_n_reg   <= n_next;
        e_d_reg   <= dv_next;
    end

    div_res_t      dv_res;
    logic [QW-1:0] dv_q;

    slcv_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (e_ctl),
        .n     (e_n_reg),
        .d     (e_d_reg),
        .res   (dv_res),
        .q     (dv_q)
    );

    // Output stage: round half up on the doubled quotient, then clamp
    logic [QW:0]   rnd;
    logic [QW-1:0] mag_r;
    logic [63:0]   lim;
    logic          sat;
    logic [63:0]   mag_f;
    logic [63:0]   value_next;

    assign rnd        = {1'b0, dv_q} + (QW+1)'(1);
    assign mag_r      = rnd[QW:1];
    assign lim        = dv_res.neg ? MAX_NEG : MAX_POS;
    assign sat        = dv_res.ovf || (mag_r > QW'(lim));
    assign mag_f      = sat ? lim : mag_r[63:0];
    assign value_next = dv_res.neg ? (64'd0 - mag_f) : mag_f;

    logic        done_reg;
    logic [63:0] value_reg;
    logic        overflow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        overflow_reg <= sat;
    end

    assign done            = done_reg;
    assign converted_value = $signed(value_reg);
    assign overflow        = overflow_reg;

    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result without matching start");

    a_pass_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && record_type_reg != REC_FULL) |-> ##LAT (done && !overflow))
        else $error("pass-through word missing or flagged");

    a_flag_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> (value_reg == MAX_POS || value_reg == MAX_NEG))
        else $error("overflow flag with unsaturated value");

endmodule

FILE: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slcv_pkg::*;

    localparam int FB = FRACTION_BITS_DEF;
    localparam logic [2:0] REG_SPARE = 3'd7;
    localparam int LATENCY = 72;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [63:0] TOP = 64'h8000_0000_0000_0000;
    localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [7:0]        rec_type;
        logic signed [9:0] mult;
        logic signed [9:0] offs;
        logic signed [3:0] offs_exp;
        logic signed [3:0] res_exp;
        logic [1:0]        fmt;
        logic [6:0]        lin;
    } record_t;

    typedef struct {
        logic [63:0] value;
        logic        ovf;
    } reading_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [7:0] raw_reading;
    logic wr_en;
    logic [2:0] wr_index;
    logic [9:0] wr_data;
    logic done;
    logic signed [63:0] converted_value;
    logic overflow;

    record_t rec;
    reading_t expected_q[$];
    int errors;
    int mismatches;
    longint cycles;
    bit no_gaps;

    sensor_reading_linear_convert_unit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .raw_reading(raw_reading), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data), .done(done), .converted_value(converted_value),
        .overflow(overflow)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] ten_to(input int e);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < e; i++)
            p = p * 64'd10;
        return p;
    endfunction

    function automatic logic [63:0] sat_mul(input logic [63:0] a, input logic [63:0] b);
        if (a != 0 && b > (64'hFFFF_FFFF_FFFF_FFFF / a))
            return 64'hFFFF_FFFF_FFFF_FFFF;
        return a * b;
    endfunction

    // round(num * 2^FB / den), ties away from zero; clamp large quotients
    function automatic logic [63:0] fixed_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] frac;
        q = num / den;
        r = num % den;
        frac = 0;
        if (q > (TOP >> FB))
            return TOP + 64'd1;
        for (int i = 0; i < FB; i++)
        begin
            r = r << 1;
            frac = frac << 1;
            if (r >= den)
            begin
                r = r - den;
                frac = frac | 64'd1;
            end
        end
        r = r << 1;
        if (r >= den)
            frac = frac + 64'd1;
        return (q << FB) + frac;
    endfunction

    function automatic reading_t clamp_sign(input logic neg, input logic [63:0] mag);
        reading_t res;
        logic [63:0] lim;
        lim = neg ? TOP : POS_LIMIT;
        res.ovf = 1'b0;
        if (mag > lim)
        begin
            mag = lim;
            res.ovf = 1'b1;
        end
        res.value = neg ? (64'd0 - mag) : mag;
        return res;
    endfunction

    function automatic reading_t convert_reading(input record_t c, input logic [7:0] raw);
        reading_t res;
        longint x;
        longint acc;
        int bexp;
        int rexp;
        int emin;
        logic neg;
        logic [63:0] mag;
        logic [63:0] num;
        logic [63:0] den;
        if (c.rec_type != REC_FULL)
        begin
            res.value = {48'd0, raw} << FB;
            res.ovf = 1'b0;
            return res;
        end
        x = (c.fmt == FMT_UNSIGNED) ? longint'(raw) : longint'($signed(raw));
        bexp = c.offs_exp;
        rexp = c.res_exp;
        emin = (bexp < 0) ? rexp + bexp : rexp;
        acc = longint'(c.mult) * x * longint'(ten_to(rexp - emin))
            + longint'(c.offs) * longint'(ten_to(rexp + bexp - emin));
        neg = acc < 0;
        mag = neg ? (64'd0 - acc) : acc;
        if (c.lin == LIN_RECIP && raw != 0)
        begin
            if (mag == 0)
            begin
                res.value = POS_LIMIT;
                res.ovf = 1'b1;
                return res;
            end
            num = (emin < 0) ? ten_to(-emin) : 64'd1;
            den = (emin > 0) ? sat_mul(mag, ten_to(emin)) : mag;
            if (den >= TOP)
            begin
                res.value = 0;
                res.ovf = 1'b0;
                return res;
            end
            return clamp_sign(neg, fixed_div(num, den));
        end
        if (emin < 0)
            return clamp_sign(neg, fixed_div(mag, ten_to(-emin)));
        return clamp_sign(neg, fixed_div(sat_mul(mag, ten_to(emin)), 64'd1));
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected word: value %h ovf %b", converted_value, overflow);
            end
            else
            begin
                reading_t e;
                e = expected_q.pop_front();
                if (converted_value !== e.value)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("converted_value mismatch: expected %h got %h",
                                 e.value, converted_value);
                end
                if (overflow !== e.ovf)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("overflow mismatch: expected %b got %b", e.ovf, overflow);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Leaves wr_en high; the caller drops it after its last write
    task automatic write_reg(input logic [2:0] idx, input logic [9:0] data);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(posedge clk);
        case (idx)
            REG_RECORD_TYPE:     rec.rec_type = data[7:0];
            REG_MULTIPLIER_M:    rec.mult = data;
            REG_OFFSET_B:        rec.offs = data;
            REG_OFFSET_EXPONENT: rec.offs_exp = data[3:0];
            REG_RESULT_EXPONENT: rec.res_exp = data[3:0];
            REG_READING_FORMAT:  rec.fmt = data[1:0];
            REG_LINEARIZATION:   rec.lin = data[6:0];
            default: ;
        endcase
    endtask

    task automatic send_reading(input logic [7:0] raw);
        if (!no_gaps)
        begin
            while ($urandom_range(0, 99) < 10)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start <= 1'b1;
        raw_reading <= raw;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_q.push_back(convert_reading(rec, raw));
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_record(input logic [7:0] rt, input logic [9:0] m, input logic [9:0] b,
                               input logic [3:0] be, input logic [3:0] re,
                               input logic [1:0] fmt, input logic [6:0] lin);
        drain();
        write_reg(REG_RECORD_TYPE, {2'b0, rt});
        write_reg(REG_MULTIPLIER_M, m);
        write_reg(REG_OFFSET_B, b);
        write_reg(REG_OFFSET_EXPONENT, {6'b0, be});
        write_reg(REG_RESULT_EXPONENT, {6'b0, re});
        write_reg(REG_READING_FORMAT, {8'b0, fmt});
        write_reg(REG_LINEARIZATION, {3'b0, lin});
        wr_en <= 1'b0;
    endtask

    task automatic test_reset_defaults;
        send_reading(8'd0);
        send_reading(8'd1);
        send_reading(8'd127);
        send_reading(8'd128);
        send_reading(8'd255);
    endtask

    task automatic test_pass_through;
        load_record(8'd0, 10'h3FF, 10'h1FF, 4'h7, 4'h7, 2'd3, LIN_RECIP);
        send_reading(8'd255);
        send_reading(8'd0);
        // out-of-range index must be ignored
        drain();
        write_reg(REG_SPARE, 10'h3FF);
        wr_en <= 1'b0;
        load_record(8'd255, 10'd1, 10'd0, 4'd0, 4'd0, 2'd0, 7'd0);
        send_reading(8'd170);
        send_reading(8'd85);
    endtask

    task automatic test_extremes;
        // large positive value, saturates
        load_record(REC_FULL, 10'h1FF, 10'h1FF, 4'h7, 4'h7, 2'd0, 7'd0);
        send_reading(8'd255);
        // large negative and positive values with signed raw
        load_record(REC_FULL, 10'h200, 10'h200, 4'h8, 4'h7, 2'd1, 7'd0);
        send_reading(8'd127);
        send_reading(8'd128);
        // very small values; the first rounds to zero
        load_record(REC_FULL, 10'h1FF, 10'h200, 4'h8, 4'h8, 2'd2, 7'd0);
        send_reading(8'd1);
        send_reading(8'd128);
    endtask

    task automatic test_reciprocal;
        // formula value zero for raw 5: reciprocal of zero
        load_record(REC_FULL, 10'd1, 10'h3FB, 4'd0, 4'd0, 2'd0, LIN_RECIP);
        send_reading(8'd5);
        send_reading(8'd0);
        send_reading(8'd3);
        // huge denominator gives a tiny reciprocal
        load_record(REC_FULL, 10'h1FF, 10'h1FF, 4'h7, 4'h7, 2'd0, LIN_RECIP);
        send_reading(8'd255);
        // tiny denominator gives a large reciprocal
        load_record(REC_FULL, 10'd1, 10'd0, 4'h8, 4'h8, 2'd3, LIN_RECIP);
        send_reading(8'd1);
        send_reading(8'd255);
    endtask

    task automatic test_random;
        logic [3:0] be;
        logic [3:0] re;
        for (int phase = 0; phase < 14; phase++)
        begin
            be = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 4'h7 : 4'h8)
                                             : 4'($urandom_range(0, 15));
            re = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 4'h7 : 4'h8)
                                             : 4'($urandom_range(0, 15));
            load_record(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : REC_FULL,
                        10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), be, re,
                        2'($urandom_range(0, 3)),
                        $urandom_range(0, 1) ? LIN_RECIP : 7'($urandom_range(0, 127)));
            no_gaps = (phase == 5);
            for (int i = 0; i < 120; i++)
            begin
                send_reading(8'($urandom_range(0, 255)));
                if (phase == 3 && i == 60)
                    drain();
            end
            no_gaps = 1'b0;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        raw_reading = 8'd0;
        wr_en = 1'b0;
        wr_index = 3'd0;
        wr_data = 10'd0;
        errors = 0;
        mismatches = 0;
        cycles = 0;
        no_gaps = 1'b0;
        rec.rec_type = REC_FULL;
        rec.mult = 10'sd1;
        rec.offs = 10'sd0;
        rec.offs_exp = 4'sd0;
        rec.res_exp = 4'sd0;
        rec.fmt = FMT_UNSIGNED;
        rec.lin = 7'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_pass_through();
        test_extremes();
        test_reciprocal();
        test_random();

        drain();
        repeat (LATENCY + 8) @(posedge clk);
        if (expected_q.size() != 0)
            errors++;
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
